### rtl/core/tpq_pkg.sv
// package for the three-class priority queue
// shared beat structs, status codes and default sizes; no dependencies
`default_nettype none

package tpq_pkg;

   localparam int DepthDefault  = 16;
   localparam int IdBitsDefault = 16;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_CLASS = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [1:0] CLS_HIGH    = 2'd0;
   localparam logic [1:0] CLS_MEDIUM  = 2'd1;
   localparam logic [1:0] CLS_LOW     = 2'd2;
   localparam logic [1:0] CLS_INVALID = 2'd3;

   typedef struct packed {
      logic        cmd;
      logic [1:0]  class_code;
      logic [15:0] arrival_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        head_valid;
      logic [15:0] head_id;
      logic [1:0]  head_class;
      logic [4:0]  count_high;
      logic [4:0]  count_medium;
      logic [4:0]  count_low;
   } rsp_type;

   // control handed from one cell to the next
   typedef struct packed {
      logic       ahead;      // new entry goes ahead of this cell
      logic       found;      // remove id matched here or further left
      logic [1:0] hit_class;  // class of the first match
   } link_type;

endpackage

`default_nettype wire

### rtl/core/tpq_cell.sv
// one slot of the sorted queue: holds a valid bit, class and id
// depends on tpq_pkg for the link struct
`default_nettype none

module tpq_cell #(
   parameter int ID_BITS = tpq_pkg::IdBitsDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               insert_en,
   input  wire logic               remove_en,
   input  wire logic [1:0]         new_class,
   input  wire logic [ID_BITS-1:0] new_id,
   input  wire logic               left_valid,
   input  wire logic [1:0]         left_class,
   input  wire logic [ID_BITS-1:0] left_id,
   input  wire logic               right_valid,
   input  wire logic [1:0]         right_class,
   input  wire logic [ID_BITS-1:0] right_id,
   input  wire tpq_pkg::link_type  link_in,
   output tpq_pkg::link_type       link_out,
   output logic                    slot_valid,
   output logic [1:0]              slot_class,
   output logic [ID_BITS-1:0]      slot_id
);
   import tpq_pkg::*;

   logic               valid_ff, valid_in;
   logic [1:0]         class_ff, class_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic               ahead_me;
   logic               match;

   always_comb begin
      if (!valid_ff) begin
         ahead_me = 1'b1;
      end else if (class_ff != new_class) begin
         ahead_me = class_ff > new_class;
      end else begin
         ahead_me = id_ff >= new_id;
      end
      match = valid_ff && (id_ff == new_id);
      link_out.ahead     = ahead_me;
      link_out.found     = link_in.found | match;
      link_out.hit_class = link_in.found ? link_in.hit_class : class_ff;
   end

   always_comb begin
      valid_in = valid_ff;
      class_in = class_ff;
      id_in    = id_ff;
      if (insert_en) begin
         if (link_in.ahead) begin
            valid_in = left_valid;
            class_in = left_class;
            id_in    = left_id;
         end else if (ahead_me) begin
            valid_in = 1'b1;
            class_in = new_class;
            id_in    = new_id;
         end
      end else if (remove_en && link_out.found) begin
         valid_in = right_valid;
         class_in = right_class;
         id_in    = right_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      class_ff <= class_in;
      id_ff    <= id_in;
   end

   assign slot_valid = valid_ff;
   assign slot_class = class_ff;
   assign slot_id    = id_ff;

endmodule

`default_nettype wire

### rtl/core/three_class_priority_queue.sv
// top level of the three-class priority queue: row of tpq_cell slots,
// class counters and the registered response beat; depends on tpq_pkg
//
// usage:
//   req channel: drive req_data and raise start; a beat is taken at a rising
//   edge with start high and busy low. busy stays low, so a command can be
//   taken in every cycle.
//   rsp channel: one beat per command, on rsp_data with rsp_strobe high for
//   exactly one cycle, the cycle after the command was taken. it carries the
//   status, the head entry and the class counts after the command.
//   throughput: 1 command per cycle. every slot compares
//   the new id in parallel and shifts one place toward its neighbor, and the
//   remove match ripples as a prefix flag along the row of DEPTH cells.
//   reset: synchronous; all slots empty, counts zero, no rsp beat pending.
//   the receiver cannot stall: a rsp beat not taken in its cycle is lost.
//   a rejected command (bad class, full table, id not found) leaves the
//   table unchanged and only reports its status.
`default_nettype none

module three_class_priority_queue #(
   parameter int DEPTH   = tpq_pkg::DepthDefault,
   parameter int ID_BITS = tpq_pkg::IdBitsDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire tpq_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output tpq_pkg::rsp_type      rsp_data
);
   import tpq_pkg::*;

   logic               accept;
   logic [ID_BITS-1:0] new_id;
   logic               full;
   logic               insert_en;
   logic               remove_en;
   logic [1:0]         status_in;

   logic [DEPTH-1:0]   vld;
   logic [1:0]         cls [DEPTH];
   logic [ID_BITS-1:0] ids [DEPTH];
   link_type           link [DEPTH+1];

   logic               rsp_strobe_ff;
   logic [1:0]         status_ff;
   logic [4:0]         cnt_high_ff, cnt_high_in;
   logic [4:0]         cnt_med_ff, cnt_med_in;
   logic [4:0]         cnt_low_ff, cnt_low_in;

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign new_id  = ID_BITS'(req_data.arrival_id);
   assign full    = vld[DEPTH-1];
   assign link[0] = '{ahead: 1'b0, found: 1'b0, hit_class: CLS_HIGH};

   always_comb begin
      insert_en = 1'b0;
      remove_en = 1'b0;
      status_in = ST_OK;
      if (req_data.cmd == CMD_INSERT) begin
         if (req_data.class_code == CLS_INVALID) begin
            status_in = ST_BAD_CLASS;
         end else if (full) begin
            status_in = ST_FULL;
         end else begin
            insert_en = accept;
         end
      end else begin
         if (!link[DEPTH].found) begin
            status_in = ST_NOT_FOUND;
         end else begin
            remove_en = accept;
         end
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic               l_valid, r_valid;
      logic [1:0]         l_class, r_class;
      logic [ID_BITS-1:0] l_id, r_id;

      if (i == 0) begin : g_first
         assign l_valid = 1'b0;
         assign l_class = CLS_HIGH;
         assign l_id    = '0;
      end else begin : g_mid
         assign l_valid = vld[i-1];
         assign l_class = cls[i-1];
         assign l_id    = ids[i-1];
      end

      if (i == DEPTH-1) begin : g_last
         assign r_valid = 1'b0;
         assign r_class = CLS_HIGH;
         assign r_id    = '0;
      end else begin : g_inner
         assign r_valid = vld[i+1];
         assign r_class = cls[i+1];
         assign r_id    = ids[i+1];
      end

      tpq_cell #(
         .ID_BITS(ID_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .insert_en  (insert_en),
         .remove_en  (remove_en),
         .new_class  (req_data.class_code),
         .new_id     (new_id),
         .left_valid (l_valid),
         .left_class (l_class),
         .left_id    (l_id),
         .right_valid(r_valid),
         .right_class(r_class),
         .right_id   (r_id),
         .link_in    (link[i]),
         .link_out   (link[i+1]),
         .slot_valid (vld[i]),
         .slot_class (cls[i]),
         .slot_id    (ids[i])
      );
   end

   always_comb begin
      cnt_high_in = cnt_high_ff;
      cnt_med_in  = cnt_med_ff;
      cnt_low_in  = cnt_low_ff;
      if (insert_en) begin
         case (req_data.class_code)
            CLS_HIGH:   cnt_high_in = cnt_high_ff + 5'd1;
            CLS_MEDIUM: cnt_med_in  = cnt_med_ff + 5'd1;
            CLS_LOW:    cnt_low_in  = cnt_low_ff + 5'd1;
            default:    cnt_high_in = cnt_high_ff;
         endcase
      end else if (remove_en) begin
         case (link[DEPTH].hit_class)
            CLS_HIGH:   cnt_high_in = cnt_high_ff - 5'd1;
            CLS_MEDIUM: cnt_med_in  = cnt_med_ff - 5'd1;
            CLS_LOW:    cnt_low_in  = cnt_low_ff - 5'd1;
            default:    cnt_high_in = cnt_high_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
         cnt_high_ff   <= '0;
         cnt_med_ff    <= '0;
         cnt_low_ff    <= '0;
      end else begin
         rsp_strobe_ff <= accept;
         cnt_high_ff   <= cnt_high_in;
         cnt_med_ff    <= cnt_med_in;
         cnt_low_ff    <= cnt_low_in;
      end
      if (accept) begin
         status_ff <= status_in;
      end
   end

   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_data.status       = status_ff;
   assign rsp_data.head_valid   = vld[0];
   assign rsp_data.head_id      = vld[0] ? 16'(ids[0]) : 16'd0;
   assign rsp_data.head_class   = vld[0] ? cls[0] : CLS_HIGH;
   assign rsp_data.count_high   = cnt_high_ff;
   assign rsp_data.count_medium = cnt_med_ff;
   assign rsp_data.count_low    = cnt_low_ff;

`ifndef SYNTHESIS
   // one rsp beat for every command taken, in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("rsp beat missing after command");

   assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("rsp beat without command");

   // occupied slots always form a prefix of the row
   assert property (@(posedge clock) disable iff (reset)
      (vld & (vld + DEPTH'(1))) == '0)
      else $error("occupied slots not contiguous");

   // class counters track the occupied slots
   assert property (@(posedge clock) disable iff (reset)
      5'(cnt_high_ff + cnt_med_ff + cnt_low_ff) == 5'($countones(vld)))
      else $error("class counts disagree with slot occupancy");

   // a full status only when the table is full
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status == ST_FULL)) |-> full)
      else $error("full status with free slot");
`endif

endmodule

`default_nettype wire

### sim/tpq_scoreboard.sv
// scoreboard for the three-class priority queue: watches the req and rsp beats,
// keeps its own sorted table and compares every rsp beat field by field
// depends on tpq_pkg for the beat structs, status, command and class codes
module tpq_scoreboard (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  tpq_pkg::req_type req_data,
   input  logic             rsp_strobe,
   input  tpq_pkg::rsp_type rsp_data,
   output int               mismatches,
   output int               outstanding
);
   import tpq_pkg::*;

   localparam int Slots = DepthDefault;

   logic [1:0]  table_class [Slots];
   logic [15:0] table_id [Slots];
   int          table_fill;
   logic [4:0]  class_tally [3];
   rsp_type     awaited_rsp [$];
   int          error_total;

   function automatic logic lands_ahead(logic [1:0] cls, logic [15:0] id, int pos);
      if (table_class[pos] != cls) return table_class[pos] > cls;
      return table_id[pos] >= id;
   endfunction

   function automatic rsp_type queue_after(req_type beat);
      rsp_type    result;
      int         pos;
      logic [1:0] cls;
      logic [15:0] id;
      cls = beat.class_code;
      id = beat.arrival_id;
      result = '0;
      if (beat.cmd == CMD_INSERT) begin
         if (cls == CLS_INVALID) begin
            result.status = ST_BAD_CLASS;
         end else if (table_fill >= Slots) begin
            result.status = ST_FULL;
         end else begin
            pos = 0;
            while (pos < table_fill && !lands_ahead(cls, id, pos)) pos++;
            for (int k = table_fill; k > pos; k--) begin
               table_class[k] = table_class[k - 1];
               table_id[k] = table_id[k - 1];
            end
            table_class[pos] = cls;
            table_id[pos] = id;
            table_fill++;
            class_tally[cls] = class_tally[cls] + 5'd1;
            result.status = ST_OK;
         end
      end else begin
         pos = 0;
         while (pos < table_fill && table_id[pos] != id) pos++;
         if (pos >= table_fill) begin
            result.status = ST_NOT_FOUND;
         end else begin
            class_tally[table_class[pos]] = class_tally[table_class[pos]] - 5'd1;
            for (int k = pos; k + 1 < table_fill; k++) begin
               table_class[k] = table_class[k + 1];
               table_id[k] = table_id[k + 1];
            end
            table_fill--;
            result.status = ST_OK;
         end
      end
      if (table_fill > 0) begin
         result.head_valid = 1'b1;
         result.head_id = table_id[0];
         result.head_class = table_class[0];
      end
      result.count_high = class_tally[CLS_HIGH];
      result.count_medium = class_tally[CLS_MEDIUM];
      result.count_low = class_tally[CLS_LOW];
      return result;
   endfunction

   task automatic check_field(string label, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
         error_total++;
      end
   endtask

   initial begin
      error_total = 0;
      table_fill = 0;
      for (int k = 0; k < 3; k++) class_tally[k] = '0;
      mismatches = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         awaited_rsp.delete();
         table_fill = 0;
         for (int k = 0; k < 3; k++) class_tally[k] = '0;
      end else begin
         if (rsp_strobe) begin
            if (awaited_rsp.size() == 0) begin
               $display("%0t: rsp beat expected none actual %0h", $time, rsp_data);
               error_total++;
            end else begin
               want = awaited_rsp.pop_front();
               check_field("status", want.status, rsp_data.status);
               check_field("head_valid", want.head_valid, rsp_data.head_valid);
               check_field("head_id", want.head_id, rsp_data.head_id);
               check_field("head_class", want.head_class, rsp_data.head_class);
               check_field("count_high", want.count_high, rsp_data.count_high);
               check_field("count_medium", want.count_medium, rsp_data.count_medium);
               check_field("count_low", want.count_low, rsp_data.count_low);
            end
         end
         if (start && !busy) awaited_rsp.push_back(queue_after(req_data));
      end
      mismatches <= error_total;
      outstanding <= awaited_rsp.size();
   end

endmodule

### sim/three_class_priority_queue_tb.sv
// testbench top for the three-class priority queue: clock, reset, directed and
// random command beats with random gaps, and the final verdict
// depends on tpq_pkg, three_class_priority_queue and tpq_scoreboard
module three_class_priority_queue_tb;
   import tpq_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      mismatches;
   int      outstanding;

   logic [15:0] recent_ids [32];
   int          recent_ptr;

   three_class_priority_queue DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   tpq_scoreboard scoreboard (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .outstanding(outstanding)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   task automatic send_beat(logic cmd, logic [1:0] cls, logic [15:0] id, int gap);
      req_type beat;
      beat.cmd = cmd;
      beat.class_code = cls;
      beat.arrival_id = id;
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= beat;
      if (cmd == CMD_INSERT) begin
         recent_ids[recent_ptr] = id;
         recent_ptr = (recent_ptr + 1) % 32;
      end
      do @(posedge clock); while (busy);
   endtask

   task automatic insert_beat(logic [1:0] cls, logic [15:0] id);
      send_beat(CMD_INSERT, cls, id, $urandom_range(0, 13));
   endtask

   task automatic remove_beat(logic [1:0] cls, logic [15:0] id);
      send_beat(CMD_REMOVE, cls, id, $urandom_range(0, 13));
   endtask

   initial begin
      int          insert_pct;
      int          gap_max;
      int          pick;
      logic [1:0]  cls;
      logic [15:0] id;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      recent_ptr = 0;
      for (int k = 0; k < 32; k++) recent_ids[k] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // remove on an empty table, bad class on an empty table
      remove_beat(CLS_HIGH, 16'h0000);
      insert_beat(CLS_INVALID, 16'hFFFF);
      // fill all slots, with duplicate ids and extreme ids
      insert_beat(CLS_LOW, 16'hFFFF);
      insert_beat(CLS_HIGH, 16'h0000);
      insert_beat(CLS_MEDIUM, 16'h0064);
      insert_beat(CLS_HIGH, 16'h0000);
      insert_beat(CLS_MEDIUM, 16'h0032);
      insert_beat(CLS_LOW, 16'hFFFF);
      insert_beat(CLS_HIGH, 16'h0007);
      insert_beat(CLS_MEDIUM, 16'h0064);
      insert_beat(CLS_LOW, 16'h0003);
      insert_beat(CLS_HIGH, 16'hAAAA);
      insert_beat(CLS_MEDIUM, 16'h5555);
      insert_beat(CLS_LOW, 16'h0008);
      insert_beat(CLS_HIGH, 16'h0001);
      insert_beat(CLS_MEDIUM, 16'h0002);
      insert_beat(CLS_LOW, 16'hFFFE);
      insert_beat(CLS_HIGH, 16'hFFFF);
      // full table, then bad class on a full table
      insert_beat(CLS_MEDIUM, 16'h0009);
      insert_beat(CLS_INVALID, 16'h0009);
      // duplicates remove the first match in table order
      remove_beat(CLS_LOW, 16'h0000);
      remove_beat(CLS_HIGH, 16'hFFFF);
      remove_beat(CLS_MEDIUM, 16'h1234);
      remove_beat(CLS_INVALID, 16'h0064);

      for (int phase = 0; phase < 14; phase++) begin
         insert_pct = $urandom_range(10, 90);
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
         for (int n = 0; n < 50; n++) begin
            if ($urandom_range(0, 99) < insert_pct) begin
               cls = ($urandom_range(0, 15) == 0) ? CLS_INVALID : 2'($urandom_range(0, 2));
               pick = $urandom_range(0, 9);
               if (pick < 6) id = 16'($urandom_range(0, 20));
               else if (pick < 8) id = 16'($urandom);
               else id = (pick == 8) ? 16'h0000 : 16'hFFFF;
               send_beat(CMD_INSERT, cls, id, $urandom_range(0, gap_max));
            end else begin
               cls = 2'($urandom_range(0, 3));
               if ($urandom_range(0, 3) != 0) id = recent_ids[$urandom_range(0, 31)];
               else id = 16'($urandom);
               send_beat(CMD_REMOVE, cls, id, $urandom_range(0, gap_max));
            end
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
